// ===== hdl/tlbd_pkg.sv =====
package tlbd_pkg;

	// seeds loaded at reset and after each end-of-region beat
	localparam logic [15:0] SEED_T = 16'h2953;
	localparam logic [15:0] SEED_U = 16'hd9c2;
	localparam logic [15:0] SEED_V = 16'h3ff1;
	localparam logic        SEED_K = 1'b1;

	// feedback constants
	localparam logic [15:0] TAP_T = 16'ha740;
	localparam logic [15:0] TAP_U = 16'hfb10;
	localparam logic [15:0] TAP_V = 16'hb3d0;

	localparam int unsigned KEY_BITS = 8;

	typedef struct packed {
		logic [7:0] data_in;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       last_out;
	} out_t;

	// generator state
	typedef struct packed {
		logic [15:0] t;
		logic [15:0] u;
		logic [15:0] v;
		logic        kbit;
	} gen_t;

	// queued job: classified input with its key byte
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] key;
		logic       last;
	} job_t;

	// queue status seen by the front
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ===== hdl/triple_lfsr_byte_descrambler.sv =====
// Byte stream descrambler driven by three conditionally clocked 16-bit
// shift registers.
//
// Input channel  : in_valid / in_ready, beat = in_data {data_in, last_byte}.
// Output channel : out_valid / out_ready, beat = out_data {data_out, last_out}.
// Each input beat gives exactly one output beat, in order.
//
// The front stage computes the eight-bit key for the accepted beat in the
// same cycle (eight keystream steps unrolled) and pushes data and key into
// a small queue. The back stage XORs key into data into the output register.
// Path from input accept to out_valid: the queue entry, then the output
// register. Throughput: one beat per cycle while the receiver keeps
// out_ready high, set by the combinational key generation and the queue/output register pair.
//
// Reset loads the seeds into the generator and empties queue and output.
// A beat with last_byte set reloads the seeds after it, so the next beat
// starts a fresh keystream. When the receiver stalls, the output register
// holds its beat, the queue fills, and in_ready drops once it is full.
module triple_lfsr_byte_descrambler #(
	parameter int unsigned QueueDepth = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tlbd_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output tlbd_pkg::out_t out_data
);

	tlbd_pkg::qstat_t qstat;
	tlbd_pkg::job_t   push_job;
	tlbd_pkg::job_t   pop_job;
	logic             push;
	logic             pop;

	// front: accept beat, generate key, advance or reseed generator
	tlbd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.qstat    (qstat),
		.push     (push),
		.push_job (push_job)
	);

	// decoupling queue between generation and delivery
	tlbd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.qstat    (qstat)
	);

	// back: apply key, hold result for the receiver
	tlbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop_job   (pop_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== hdl/tlbd_front.sv =====
module tlbd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tlbd_pkg::in_t   in_data,
	input  tlbd_pkg::qstat_t qstat,
	output logic            push,
	output tlbd_pkg::job_t  push_job
);

	tlbd_pkg::gen_t gen_q;
	tlbd_pkg::gen_t gen_nxt;
	logic [7:0]     key;
	logic           accept;

	// one keystream bit: update running bit, then conditionally clock registers
	function automatic tlbd_pkg::gen_t step(input tlbd_pkg::gen_t g);
		tlbd_pkg::gen_t r;
		logic t0, t1, u0, u1, v0;
		t0 = g.t[0];
		t1 = g.t[1];
		u0 = g.u[0];
		u1 = g.u[1];
		v0 = g.v[0];
		r = g;
		r.kbit = g.kbit ^ t1 ^ v0 ^ (u0 | u1) ^ ((t0 ^ u1 ^ v0) & (t0 ^ u0));
		if (t0 == u0) begin
			r.v = {1'b0, g.v[15:1]} ^ (v0 ? tlbd_pkg::TAP_V : 16'h0000);
		end
		if (!t0) begin
			r.u = {1'b0, g.u[15:1]} ^ (u0 ? tlbd_pkg::TAP_U : 16'h0000);
		end
		r.t = {1'b0, g.t[15:1]} ^ (t0 ? tlbd_pkg::TAP_T : 16'h0000);
		return r;
	endfunction

	always_comb begin
		tlbd_pkg::gen_t g;
		g   = gen_q;
		key = '0;
		for (int i = 0; i < tlbd_pkg::KEY_BITS; i++) begin
			g   = step(g);
			key = {key[6:0], g.kbit};
		end
		gen_nxt = g;
	end

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept;

	assign push_job.data = in_data.data_in;
	assign push_job.key  = key;
	assign push_job.last = in_data.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '{t: tlbd_pkg::SEED_T, u: tlbd_pkg::SEED_U,
				v: tlbd_pkg::SEED_V, kbit: tlbd_pkg::SEED_K};
		end else if (accept) begin
			if (in_data.last_byte) begin
				gen_q <= '{t: tlbd_pkg::SEED_T, u: tlbd_pkg::SEED_U,
					v: tlbd_pkg::SEED_V, kbit: tlbd_pkg::SEED_K};
			end else begin
				gen_q <= gen_nxt;
			end
		end
	end

	// end of region must reseed the generator
	a_reseed: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.last_byte) |=> (gen_q.t == tlbd_pkg::SEED_T &&
			gen_q.u == tlbd_pkg::SEED_U && gen_q.v == tlbd_pkg::SEED_V &&
			gen_q.kbit == tlbd_pkg::SEED_K))
		else $error("generator not reseeded after last beat");

endmodule

// ===== hdl/tlbd_queue.sv =====
module tlbd_queue #(
	parameter int unsigned Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tlbd_pkg::job_t   push_job,
	input  logic             pop,
	output tlbd_pkg::job_t   pop_job,
	output tlbd_pkg::qstat_t qstat
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] Full    = CntW'(Depth);

	tlbd_pkg::job_t  mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign qstat.full  = (count_q == Full);
	assign qstat.empty = (count_q == '0);
	assign pop_job     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != Full || pop))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue underflow");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a beat");

endmodule

// ===== hdl/tlbd_back.sv =====
module tlbd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tlbd_pkg::qstat_t qstat,
	input  tlbd_pkg::job_t   pop_job,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output tlbd_pkg::out_t   out_data
);

	logic           valid_q;
	tlbd_pkg::out_t data_q;

	// load the output register when it is empty or being drained
	assign pop       = !qstat.empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q.data_out <= pop_job.data ^ pop_job.key;
			data_q.last_out <= pop_job.last;
		end
	end

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> (valid_q && data_q == $past(data_q)))
		else $error("stalled result overwritten");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Generous ceiling for the slowest legal run (81 % idling on either side plus the
	// long receiver hold-off).
	localparam int unsigned CYCLE_LIMIT = 200000;
	// Random beats per idling phase; three phases give roughly 1950 beats.
	localparam int unsigned PHASE_BEATS = 650;
	// Long receiver hold-off, in cycles, used to fill the block and stall its input.
	localparam int unsigned HOLD_CYCLES = 400;
	// Cycles to let pass after the last expected beat, to catch strays.
	localparam int unsigned TAIL_CYCLES = 20;

	// Keystream seeds and feedback taps, restated here for the checker's own generator.
	localparam logic [15:0] INIT_T = 16'h2953;
	localparam logic [15:0] INIT_U = 16'hd9c2;
	localparam logic [15:0] INIT_V = 16'h3ff1;
	localparam logic        INIT_K = 1'b1;
	localparam logic [15:0] FB_T   = 16'ha740;
	localparam logic [15:0] FB_U   = 16'hfb10;
	localparam logic [15:0] FB_V   = 16'hb3d0;

	// Directed beats: {data_in, last_byte}.
	localparam tlbd_pkg::in_t DIR_ROWS [22] = '{
		'{8'h00, 1'b1},  // one-byte region straight after reset: output is the bare key
		'{8'hff, 1'b1},  // same fresh key again, all data bits set
		'{8'hff, 1'b1},  // back-to-back region ends
		'{8'h00, 1'b0},  // start of a longer region, keystream runs on
		'{8'h00, 1'b0},
		'{8'h00, 1'b0},
		'{8'hff, 1'b0},
		'{8'h80, 1'b0},  // single-bit data, top and bottom
		'{8'h01, 1'b0},
		'{8'h55, 1'b0},
		'{8'haa, 1'b1},  // end of region mid-stream
		'{8'h00, 1'b1},
		'{8'h7f, 1'b0},
		'{8'hfe, 1'b0},
		'{8'h0f, 1'b0},
		'{8'hf0, 1'b0},
		'{8'h33, 1'b0},
		'{8'hcc, 1'b0},
		'{8'h5a, 1'b0},
		'{8'ha5, 1'b0},
		'{8'h00, 1'b0},
		'{8'hff, 1'b1}
	};

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           in_valid  = 1'b0;
	logic           in_ready;
	tlbd_pkg::in_t  in_data   = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	tlbd_pkg::out_t out_data;

	// checker's copy of the keystream generator
	tlbd_pkg::gen_t   gen;
	// plain bytes still owed by the block, oldest first
	tlbd_pkg::out_t   plain_q [$];

	int unsigned send_idle   = 0;   // percent of cycles the sender idles
	int unsigned recv_idle   = 0;   // percent of cycles the receiver stalls
	int unsigned rx_hold     = 0;   // remaining cycles of a forced receiver hold-off
	int unsigned beats_sent  = 0;
	int unsigned fail_cnt    = 0;
	int unsigned cycle_cnt   = 0;

	triple_lfsr_byte_descrambler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// Watchdog: any hang ends the run as a failure.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $realtime, cycle_cnt);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic void reload_seeds();
		gen.t    = INIT_T;
		gen.u    = INIT_U;
		gen.v    = INIT_V;
		gen.kbit = INIT_K;
	endfunction

	// Eight keystream steps, MSB first. The running bit mixes the low bits of
	// t, u and v; v steps when t[0] == u[0], u steps when t[0] is clear, t always
	// steps, and a stepping register folds in its tap when a one falls out.
	function automatic logic [7:0] key_byte();
		logic [7:0] key;
		logic       t0, t1, u0, u1, v0, b;
		key = '0;
		for (int i = 0; i < 8; i++) begin
			t0 = gen.t[0];
			t1 = gen.t[1];
			u0 = gen.u[0];
			u1 = gen.u[1];
			v0 = gen.v[0];
			b  = gen.kbit ^ t1 ^ v0 ^ (u0 | u1) ^ ((t0 ^ u1 ^ v0) & (t0 ^ u0));
			gen.kbit = b;
			if (t0 == u0)
				gen.v = (gen.v >> 1) ^ (v0 ? FB_V : 16'h0000);
			if (!t0)
				gen.u = (gen.u >> 1) ^ (u0 ? FB_U : 16'h0000);
			gen.t = (gen.t >> 1) ^ (t0 ? FB_T : 16'h0000);
			key = {key[6:0], b};
		end
		return key;
	endfunction

	// Work out the plain byte owed for an accepted scrambled beat.
	function automatic void descramble(tlbd_pkg::in_t beat);
		tlbd_pkg::out_t plain;
		plain.data_out = beat.data_in ^ key_byte();
		plain.last_out = beat.last_byte;
		plain_q.push_back(plain);
		// end of region: the next beat starts a fresh keystream
		if (beat.last_byte)
			reload_seeds();
	endfunction

	// Offer one beat and hold it until accepted. Returns at the accepting edge,
	// so the next beat may follow back-to-back without dropping valid.
	task automatic send_beat(tlbd_pkg::in_t beat);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		descramble(beat);
		beats_sent++;
	endtask

	// Whole regions of random bytes: mostly short, some medium, a few long.
	task automatic send_regions(int unsigned n_beats);
		int unsigned   stop_at;
		int unsigned   len;
		int unsigned   pick;
		tlbd_pkg::in_t beat;
		stop_at = beats_sent + n_beats;
		while (beats_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 80)
				len = $urandom_range(16, 1);
			else if (pick < 95)
				len = $urandom_range(64, 17);
			else
				len = $urandom_range(300, 65);
			for (int i = 0; i < len; i++) begin
				beat.data_in   = 8'($urandom_range(255));
				beat.last_byte = (i == len - 1);
				send_beat(beat);
			end
		end
	endtask

	// Stop offering and wait for every owed byte to come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (plain_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic void check_beat(tlbd_pkg::out_t got);
		tlbd_pkg::out_t want;
		if (plain_q.size() == 0) begin
			fail_cnt++;
			$display("%0t: expected no beat, got data_out=%h last_out=%b",
				$realtime, got.data_out, got.last_out);
			return;
		end
		want = plain_q.pop_front();
		if (got.data_out !== want.data_out) begin
			fail_cnt++;
			$display("%0t: data_out expected %h got %h",
				$realtime, want.data_out, got.data_out);
		end
		if (got.last_out !== want.last_out) begin
			fail_cnt++;
			$display("%0t: last_out expected %b got %b",
				$realtime, want.last_out, got.last_out);
		end
	endfunction

	// Receiver: checks each accepted beat, then picks ready for the next cycle.
	// A forced hold-off is counted down here, independent of the sender.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1)
				check_beat(out_data);
			if (rx_hold != 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Sender and sequencing of the run.
	initial begin
		reload_seeds();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats, no idling on either side
		foreach (DIR_ROWS[i])
			send_beat(DIR_ROWS[i]);
		drain();

		// sender mostly busy, receiver mostly stalled
		send_idle = 7;
		recv_idle = 81;
		send_regions(PHASE_BEATS);
		// sender pause until the block has emptied
		drain();

		// the other way round
		send_idle = 81;
		recv_idle = 7;
		send_regions(PHASE_BEATS);
		drain();

		// full rate; opens with a long receiver hold-off while the sender keeps
		// offering, so the queue fills and in_ready has to drop
		send_idle = 0;
		recv_idle = 0;
		rx_hold   = HOLD_CYCLES;
		send_regions(PHASE_BEATS);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/tlbd_pkg.sv
hdl/tlbd_front.sv
hdl/tlbd_queue.sv
hdl/tlbd_back.sv
hdl/triple_lfsr_byte_descrambler.sv
tb/sv/tb.sv
